@@ sv/hopf_pkg.sv @@
// ----------------------------------------------------------------------------
// hopf_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the Hopfield associative recall block.
// ----------------------------------------------------------------------------
package hopf_pkg;

   localparam int DEF_NEURONS     = 32;
   localparam int DEF_WEIGHT_BITS = 8;
   localparam int MAX_NEURONS     = 64;

   localparam int OP_W  = 2;
   localparam int PAT_W = 32;
   localparam int IDX_W = 5;

   localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic learn_rd;   // read weight row at the counter
      logic learn_wr;   // write updated weight row at counter minus one
      logic upd_rd;     // read weight row of the addressed neuron
      logic acc_clr;    // clear the input-sum accumulator
      logic acc_step;   // add one weight times state term
      logic finish;     // commit neuron state and load the response register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            idx_ok;
      logic            out_free;
   } sts_type;

endpackage

@@ sv/hopf_datapath.sv @@
// ----------------------------------------------------------------------------
// hopf_datapath
// Request latch, neuron state, weight row memory with row valid bits, Hebbian
// row update, serial weighted-sum accumulator and the response register.
// ----------------------------------------------------------------------------
module hopf_datapath
   import hopf_pkg::*;
#(
   parameter int NEURONS     = DEF_NEURONS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   localparam int CNT_W      = $clog2(NEURONS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [CNT_W-1:0]  cnt,
   output sts_type           sts,
   input  logic [OP_W-1:0]   req_op,
   input  logic [PAT_W-1:0]  req_pattern_bits,
   input  logic [IDX_W-1:0]  req_neuron_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PAT_W-1:0]  rsp_state_bits,
   output logic              rsp_new_value,
   output logic              rsp_changed
);

   localparam int IW = $clog2(NEURONS);
   localparam int WB = WEIGHT_BITS;
   localparam int RW = NEURONS * WB;
   localparam int AW = WB + IW + 1;
   localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

   logic [OP_W-1:0]      op_ff;
   logic [NEURONS-1:0]   pat_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [NEURONS-1:0]   nstate_ff, nstate_in;
   logic [RW-1:0]        mem [NEURONS];
   logic [NEURONS-1:0]   row_vld_ff;
   logic [RW-1:0]        rd_ff;
   logic                 rd_vld_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 rsp_valid_ff;
   logic [PAT_W-1:0]     rsp_state_ff, rsp_state_in;
   logic                 rsp_nv_ff, rsp_nv_in;
   logic                 rsp_ch_ff, rsp_ch_in;

   logic [MAX_NEURONS-1:0] pat_ext;
   logic [MAX_NEURONS-1:0] st_ext;
   logic                   idx_ok;
   logic                   upd_ok;
   logic [IW-1:0]          upd_row;
   logic [IW-1:0]          rd_row;
   logic [CNT_W-1:0]       cnt_m1;
   logic [IW-1:0]          wr_row;
   logic [IW-1:0]          col;
   logic [RW-1:0]          row_eff;
   logic [RW-1:0]          wr_data;
   logic signed [WB-1:0]   w_cur;

   assign pat_ext = MAX_NEURONS'(req_pattern_bits);
   assign idx_ok  = (32'(idx_ff) < 32'(NEURONS));
   assign upd_ok  = (op_ff == OP_UPDATE) && idx_ok;
   assign upd_row = IW'(idx_ff);
   assign cnt_m1  = cnt - CNT_W'(1);
   assign wr_row  = cnt_m1[IW-1:0];
   assign rd_row  = cmd.learn_rd ? cnt[IW-1:0] : upd_row;
   assign col     = cnt[IW-1:0];
   // a row never written reads as all-zero weights
   assign row_eff = rd_vld_ff ? rd_ff : '0;
   assign w_cur   = row_eff[col*WB +: WB];

   assign sts.op       = op_ff;
   assign sts.idx_ok   = idx_ok;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         pat_ff <= pat_ext[NEURONS-1:0];
         idx_ff <= req_neuron_index;
      end
   end

   // Hebbian row update with saturation; diagonal forced to zero
   always_comb begin
      logic signed [WB-1:0] w_old;
      logic                 agree;
      wr_data = '0;
      for (int c = 0; c < NEURONS; c++) begin
         w_old = row_eff[c*WB +: WB];
         agree = pat_ff[wr_row] ~^ pat_ff[c];
         if (IW'(c) == wr_row) begin
            wr_data[c*WB +: WB] = '0;
         end else if (agree) begin
            wr_data[c*WB +: WB] = (w_old == WMAX) ? w_old : w_old + WB'(1);
         end else begin
            wr_data[c*WB +: WB] = (w_old == WMIN) ? w_old : w_old - WB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.learn_wr) begin
         mem[wr_row] <= wr_data;
      end
      if (cmd.learn_rd || cmd.upd_rd) begin
         rd_ff     <= mem[rd_row];
         rd_vld_ff <= row_vld_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (cmd.learn_wr) begin
         row_vld_ff[wr_row] <= 1'b1;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_step) begin
         acc_in = nstate_ff[col] ? acc_ff + AW'(w_cur) : acc_ff - AW'(w_cur);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      nstate_in = nstate_ff;
      rsp_nv_in = 1'b0;
      rsp_ch_in = 1'b0;
      if (op_ff == OP_LOAD) begin
         nstate_in = pat_ff;
      end else if (upd_ok) begin
         rsp_nv_in          = ~acc_ff[AW-1];
         rsp_ch_in          = rsp_nv_in ^ nstate_ff[upd_row];
         nstate_in[upd_row] = rsp_nv_in;
      end
      st_ext                = '0;
      st_ext[NEURONS-1:0]   = nstate_in;
      rsp_state_in          = st_ext[PAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         nstate_ff    <= nstate_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_state_ff <= rsp_state_in;
         rsp_nv_ff    <= rsp_nv_in;
         rsp_ch_ff    <= rsp_ch_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_state_bits = rsp_state_ff;
   assign rsp_new_value  = rsp_nv_ff;
   assign rsp_changed    = rsp_ch_ff;

endmodule

@@ sv/hopf_ctrl.sv @@
// ----------------------------------------------------------------------------
// hopf_ctrl
// Sequencer: accepts one request, steps the weight rows for learn or the
// columns of one row for update, then hands the result to the output.
// ----------------------------------------------------------------------------
module hopf_ctrl
   import hopf_pkg::*;
#(
   parameter int NEURONS = DEF_NEURONS,
   localparam int CNT_W  = $clog2(NEURONS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output cmd_type          cmd,
   output logic [CNT_W-1:0] cnt,
   input  sts_type          sts
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DISP  = 3'd1;
   localparam logic [2:0] ST_LEARN = 3'd2;
   localparam logic [2:0] ST_URD   = 3'd3;
   localparam logic [2:0] ST_UACC  = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   localparam logic [CNT_W-1:0] LEARN_LAST = CNT_W'(NEURONS);
   localparam logic [CNT_W-1:0] ACC_LAST   = CNT_W'(NEURONS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign cnt       = cnt_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISP;
            end
         end
         ST_DISP: begin
            cnt_in = '0;
            if (sts.op == OP_LEARN) begin
               state_in = ST_LEARN;
            end else if (sts.op == OP_UPDATE && sts.idx_ok) begin
               state_in = ST_URD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LEARN: begin
            // read row cnt, write back row cnt-1 from the registered read
            cmd.learn_rd = (cnt_ff != LEARN_LAST);
            cmd.learn_wr = (cnt_ff != '0);
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == LEARN_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_URD: begin
            cmd.upd_rd  = 1'b1;
            cmd.acc_clr = 1'b1;
            cnt_in      = '0;
            state_in    = ST_UACC;
         end
         ST_UACC: begin
            cmd.acc_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == ACC_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the response register is free
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ sv/hopfield_associative_recall_top.sv @@
// ----------------------------------------------------------------------------
// hopfield_associative_recall_top
// Binary Hopfield associative memory: Hebbian learn, state load, and
// single-neuron recall update.
//
// Requests arrive on req_* (valid/ready); each yields exactly one response on
// rsp_* (valid/ready) carrying the neuron state after the operation.
// Requests are processed one at a time. Learn reads and writes back one weight
// row per cycle, update accumulates one weight times state term per cycle, and
// load, an unused op or an out-of-range index goes straight to the response.
// The next request is taken as soon as the sequencer is idle, even while the
// previous response waits in the output register; if the receiver stalls,
// the sequencer holds in its final step until the output register frees.
// Reset clears the weight store (per-row valid bits, so no clearing pass),
// sets every neuron to +1 and drops any pending response.
// ----------------------------------------------------------------------------
module hopfield_associative_recall_top
   import hopf_pkg::*;
#(
   parameter int NEURONS     = DEF_NEURONS,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [OP_W-1:0]  req_op,
   input  logic [PAT_W-1:0] req_pattern_bits,
   input  logic [IDX_W-1:0] req_neuron_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PAT_W-1:0] rsp_state_bits,
   output logic             rsp_new_value,
   output logic             rsp_changed
);

   localparam int CNT_W = $clog2(NEURONS + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic [CNT_W-1:0] cnt;

   hopf_ctrl #(
      .NEURONS (NEURONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .cnt       (cnt),
      .sts       (sts)
   );

   hopf_datapath #(
      .NEURONS     (NEURONS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cnt              (cnt),
      .sts              (sts),
      .req_op           (req_op),
      .req_pattern_bits (req_pattern_bits),
      .req_neuron_index (req_neuron_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_state_bits   (rsp_state_bits),
      .rsp_new_value    (rsp_new_value),
      .rsp_changed      (rsp_changed)
   );

endmodule

@@ test/tb_hopfield_associative_recall_top.sv @@
// ----------------------------------------------------------------------------
// tb_hopfield_associative_recall_top
// Self-checking bench for the Hopfield associative recall block. A directed
// pass covers the pattern extremes, every operation, the unused op code and
// weight saturation. Random recall episodes follow: learn a few patterns,
// load a corrupted copy and run single-neuron updates, mixed with saturation
// bursts and raw noise. Both handshake sides stall at random, and every
// response is checked against a cycle-free model of the weight store and the
// neuron state.
// ----------------------------------------------------------------------------
module tb_hopfield_associative_recall_top
   import hopf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NEURONS     = DEF_NEURONS;
   localparam int WEIGHT_BITS = DEF_WEIGHT_BITS;
   localparam int W_MAX       = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam int W_MIN       = -(1 << (WEIGHT_BITS - 1));
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1550;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 3 * (NEURONS + 4);

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [PAT_W-1:0] pattern;
      logic [IDX_W-1:0] index;
   } recall_req_type;

   typedef struct packed {
      logic [PAT_W-1:0] state_bits;
      logic             new_value;
      logic             changed;
   } recall_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [OP_W-1:0]  req_op = OP_LEARN;
   logic [PAT_W-1:0] req_pattern_bits = '0;
   logic [IDX_W-1:0] req_neuron_index = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PAT_W-1:0] rsp_state_bits;
   logic             rsp_new_value;
   logic             rsp_changed;

   hopfield_associative_recall_top #(
      .NEURONS     (NEURONS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pattern_bits (req_pattern_bits),
      .req_neuron_index (req_neuron_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_state_bits   (rsp_state_bits),
      .rsp_new_value    (rsp_new_value),
      .rsp_changed      (rsp_changed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   recall_req_type pending_reqs[$];
   recall_rsp_type expected_states[$];
   int unsigned errors = 0;
   int unsigned queued_items = 0;
   int unsigned cycle_count = 0;

   // model of the block: Hebbian weights and the +-1 neuron state
   logic signed [WEIGHT_BITS-1:0] hebb_w [NEURONS][NEURONS];
   logic [PAT_W-1:0]              neuron_bits;

   function automatic int polarity(input logic b);
      return b ? 1 : -1;
   endfunction

   function automatic int unsigned pick_gap(inout int unsigned run_left);
      if (run_left != 0) begin
         run_left--;
         return 0;
      end
      // occasionally open a stretch with no idling at all
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   task automatic recall_predict(input recall_req_type r);
      recall_rsp_type res;
      int             acc;
      int             v;
      logic           nv;
      res = '0;
      case (r.op)
         OP_LEARN: begin
            for (int i = 0; i < NEURONS; i++) begin
               for (int j = 0; j < NEURONS; j++) begin
                  if (i == j) begin
                     hebb_w[i][j] = '0;
                  end else begin
                     v = int'(hebb_w[i][j]) + polarity(r.pattern[i]) * polarity(r.pattern[j]);
                     if (v > W_MAX) v = W_MAX;
                     if (v < W_MIN) v = W_MIN;
                     hebb_w[i][j] = v[WEIGHT_BITS-1:0];
                  end
               end
            end
         end
         OP_LOAD: begin
            neuron_bits = r.pattern;
         end
         OP_UPDATE: begin
            acc = 0;
            for (int k = 0; k < NEURONS; k++)
               acc += int'(hebb_w[r.index][k]) * polarity(neuron_bits[k]);
            nv = (acc >= 0);
            res.new_value = nv;
            res.changed = (nv != neuron_bits[r.index]);
            neuron_bits[r.index] = nv;
         end
         default: ;
      endcase
      res.state_bits = neuron_bits;
      expected_states.push_back(res);
   endtask

   function automatic void push_req(input logic [OP_W-1:0] op, input logic [PAT_W-1:0] pat,
                                    input logic [IDX_W-1:0] idx);
      recall_req_type r;
      r.op = op;
      r.pattern = pat;
      r.index = idx;
      pending_reqs.push_back(r);
      queued_items++;
   endfunction

   // request driver
   int unsigned send_wait = 0;
   int unsigned send_run = 0;

   always @(posedge clock) begin
      recall_req_type nxt;
      logic           holding;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= pick_gap(send_run);
         expected_states.delete();
         neuron_bits = '1;
         for (int i = 0; i < NEURONS; i++)
            for (int j = 0; j < NEURONS; j++)
               hebb_w[i][j] = '0;
      end else begin
         if (req_valid && req_ready)
            recall_predict({req_op, req_pattern_bits, req_neuron_index});
         holding = req_valid && !req_ready;
         if (!holding) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_op <= nxt.op;
               req_pattern_bits <= nxt.pattern;
               req_neuron_index <= nxt.index;
               req_valid <= 1'b1;
               send_wait <= pick_gap(send_run);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   int unsigned recv_wait = 0;
   int unsigned recv_run = 0;

   always @(posedge clock) begin
      recall_rsp_type want;
      int unsigned    w;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_states.size() == 0) begin
            $error("response with none outstanding: state_bits %h", rsp_state_bits);
            errors++;
         end else begin
            want = expected_states.pop_front();
            if (rsp_state_bits !== want.state_bits) begin
               $error("state_bits: expected %h, got %h", want.state_bits, rsp_state_bits);
               errors++;
            end
            if (rsp_new_value !== want.new_value) begin
               $error("new_value: expected %b, got %b", want.new_value, rsp_new_value);
               errors++;
            end
            if (rsp_changed !== want.changed) begin
               $error("changed: expected %b, got %b", want.changed, rsp_changed);
               errors++;
            end
         end
         w = pick_gap(recv_run);
         recv_wait <= w;
         rsp_ready <= (w == 0);
      end else if (recv_wait != 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= (recv_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_hopfield_associative_recall_top: done, errors");
         $finish;
      end
   end

   initial begin
      logic [PAT_W-1:0] stored [4];
      logic [PAT_W-1:0] probe;
      int unsigned      n_pat;
      int unsigned      sel;
      int unsigned      r;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero weights, extremes, every op and the unused code
      push_req(OP_UPDATE, '0, 5'd0);
      push_req(OP_UNUSED, 32'hDEAD_BEEF, 5'd9);
      push_req(OP_LOAD, 32'h0000_0000, 5'd0);
      push_req(OP_UPDATE, '0, 5'd31);
      push_req(OP_LEARN, 32'hFFFF_FFFF, 5'd0);
      push_req(OP_LEARN, 32'h0000_0000, 5'd31);
      push_req(OP_LEARN, 32'hAAAA_AAAA, 5'd0);
      push_req(OP_LOAD, 32'h5555_5555, 5'd0);
      push_req(OP_UPDATE, '1, 5'd0);
      push_req(OP_UPDATE, '1, 5'd31);
      push_req(OP_UPDATE, '0, 5'd17);
      push_req(OP_LOAD, 32'hFFFF_0000, 5'd31);
      push_req(OP_UPDATE, '0, 5'd5);
      push_req(OP_UPDATE, '0, 5'd16);
      push_req(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
      push_req(OP_LEARN, 32'h8000_0001, 5'd0);
      push_req(OP_LOAD, 32'h0000_0001, 5'd0);
      push_req(OP_UPDATE, '0, 5'd31);
      push_req(OP_UPDATE, '0, 5'd0);
      push_req(OP_UNUSED, 32'h0000_0000, 5'd0);

      // hold the sender until every outstanding response is back
      while (pending_reqs.size() != 0 || req_valid || expected_states.size() != 0)
         @(posedge clock);

      // drive both weight limits: alternating bits saturate up and down
      repeat (135) push_req(OP_LEARN, 32'hAAAA_AAAA, IDX_W'($urandom_range(0, 31)));
      push_req(OP_LOAD, 32'hAAAA_AAA5, 5'd0);
      for (int k = 0; k < 8; k++)
         push_req(OP_UPDATE, $urandom, IDX_W'($urandom_range(0, 31)));

      while (queued_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            // recall episode: store patterns, load a noisy copy, relax
            n_pat = $urandom_range(1, 4);
            for (int k = 0; k < n_pat; k++) begin
               stored[k] = $urandom;
               push_req(OP_LEARN, stored[k], IDX_W'($urandom));
            end
            sel = $urandom_range(0, n_pat - 1);
            probe = stored[sel];
            repeat ($urandom_range(0, 8)) probe[$urandom_range(0, 31)] ^= 1'b1;
            push_req(OP_LOAD, probe, IDX_W'($urandom));
            repeat ($urandom_range(8, 48))
               push_req(OP_UPDATE, $urandom, IDX_W'($urandom_range(0, 31)));
         end else if (r < 64) begin
            probe = $urandom;
            repeat ($urandom_range(120, 140)) push_req(OP_LEARN, probe, IDX_W'($urandom));
            push_req(OP_LOAD, $urandom, IDX_W'($urandom));
            repeat ($urandom_range(4, 16))
               push_req(OP_UPDATE, $urandom, IDX_W'($urandom_range(0, 31)));
         end else begin
            repeat ($urandom_range(4, 12))
               push_req(OP_W'($urandom_range(0, 3)), $urandom, IDX_W'($urandom_range(0, 31)));
         end
      end

      while (pending_reqs.size() != 0 || req_valid || expected_states.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_states.size() == 0) begin
         $display("tb_hopfield_associative_recall_top: done, clean");
      end else begin
         $display("tb_hopfield_associative_recall_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/hopf_pkg.sv
sv/hopf_datapath.sv
sv/hopf_ctrl.sv
sv/hopfield_associative_recall_top.sv
test/tb_hopfield_associative_recall_top.sv
